### rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SCLP_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SCLP_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SCLP_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define SCLP_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif

`endif

### rtl/sclp_pkg.sv
package sclp_pkg;

  localparam int LINE_MAX     = 32;
  localparam int STAGE_COUNT  = 14;
  localparam int REVERSE_BASE = 7;

  localparam int ADDR_W = $clog2(LINE_MAX);
  localparam int LEN_W  = $clog2(LINE_MAX + 1);
  localparam int STG_W  = 6;
  localparam int SACC_W = 7;
  localparam int ARG_W  = 31;

  localparam logic [ARG_W-1:0] SAT_MAX = {ARG_W{1'b1}};

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef enum logic [3:0] {
    CMD_IDLE   = 4'd0,
    CMD_TRACK  = 4'd1,
    CMD_MANUAL = 4'd2,
    CMD_RECAL  = 4'd3,
    CMD_STATUS = 4'd4,
    CMD_CALQ   = 4'd5,
    CMD_CFGQ   = 4'd6,
    CMD_HELP   = 4'd7,
    CMD_PERIOD = 4'd8,
    CMD_STAGE  = 4'd9
  } cmd_code_t;

  typedef enum logic [1:0] {
    SM_NUM = 2'd0,
    SM_F   = 2'd1,
    SM_R   = 2'd2
  } stg_mode_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_TRIM_S = 5'b00010,
    ST_TRIM_E = 5'b00100,
    ST_MATCH  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  typedef struct packed {
    logic       clr;
    logic       en;
    logic       first;
    logic [7:0] c;
  } stg_ctl_t;

  typedef struct packed {
    logic             ok;
    stg_mode_t        mode;
    logic [STG_W-1:0] val;
  } stg_res_t;

  localparam int KW_N = 11;

  localparam logic [63:0] KW_TXT [KW_N] = '{
    64'("IDLE"), 64'("0"), 64'("TRACK"), 64'("1"), 64'("MANUAL"), 64'("2"),
    64'("RECAL"), 64'("STATUS"), 64'("CAL?"), 64'("CFG?"), 64'("HELP")};
  localparam int KW_LEN [KW_N] = '{4, 1, 5, 1, 6, 1, 5, 6, 4, 4, 4};
  localparam cmd_code_t KW_CODE [KW_N] = '{
    CMD_IDLE, CMD_IDLE, CMD_TRACK, CMD_TRACK, CMD_MANUAL, CMD_MANUAL,
    CMD_RECAL, CMD_STATUS, CMD_CALQ, CMD_CFGQ, CMD_HELP};

  localparam logic [63:0] PER_TXT = 64'("PERIOD ");
  localparam int          PER_LEN = 7;
  localparam logic [63:0] MAN_TXT = 64'("MAN ");
  localparam int          MAN_LEN = 4;

  // byte i of a right-aligned text of length l
  function automatic logic [7:0] txt_byte(input logic [63:0] s, input int l, input int i);
    logic [63:0] sh;
    sh = s >> (8 * (l - 1 - i));
    return sh[7:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
  endfunction

endpackage

### rtl/sclp_in_if.sv
interface sclp_in_if import sclp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/sclp_out_if.sv
interface sclp_out_if import sclp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [3:0]       cmd_code;
  logic [ARG_W-1:0] cmd_arg;

  modport source (output valid, output cmd_code, output cmd_arg, input ready);
  modport sink   (input valid, input cmd_code, input cmd_arg, output ready);
endinterface

### rtl/sclp_stage.sv
module sclp_stage import sclp_pkg::*; (
  input  logic     clk,
  input  stg_ctl_t ctl,
  output stg_res_t res
);

  stg_mode_t         mode_r, mode_nxt;
  logic              bad_r, bad_nxt;
  logic              dig_r, dig_nxt;
  logic [SACC_W-1:0] acc_r, acc_nxt;
  logic [SACC_W+3:0] prod;
  logic [SACC_W-1:0] d;
  logic [SACC_W-1:0] lim;

  always_comb begin
    mode_nxt = mode_r;
    bad_nxt  = bad_r;
    dig_nxt  = dig_r;
    acc_nxt  = acc_r;
    d        = SACC_W'(ctl.c - 8'h30);
    prod     = (SACC_W+4)'(acc_r) * (SACC_W+4)'(10) + (SACC_W+4)'(d);
    if (ctl.clr) begin
      mode_nxt = SM_NUM;
      bad_nxt  = 1'b0;
      dig_nxt  = 1'b0;
      acc_nxt  = '0;
    end else if (ctl.en && ctl.first) begin
      if (ctl.c == 8'h46) begin
        mode_nxt = SM_F;
      end else if (ctl.c == 8'h52) begin
        mode_nxt = SM_R;
      end else if (is_digit(ctl.c)) begin
        mode_nxt = SM_NUM;
        acc_nxt  = d;
        dig_nxt  = 1'b1;
      end else begin
        bad_nxt = 1'b1;
      end
    end else if (ctl.en) begin
      if (is_digit(ctl.c)) begin
        dig_nxt = 1'b1;
        acc_nxt = (prod > (SACC_W+4)'({SACC_W{1'b1}})) ? {SACC_W{1'b1}} : prod[SACC_W-1:0];
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    bad_r  <= bad_nxt;
    dig_r  <= dig_nxt;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    lim      = (mode_r == SM_NUM) ? SACC_W'(STAGE_COUNT) : SACC_W'(REVERSE_BASE);
    res.mode = mode_r;
    res.ok   = !bad_r && dig_r && (acc_r != '0) && (acc_r <= lim);
    res.val  = (mode_r == SM_R) ? STG_W'(STG_W'(REVERSE_BASE) + STG_W'(acc_r) - 1'b1)
                                : STG_W'(STG_W'(acc_r) - 1'b1);
  end

endmodule

### rtl/serial_command_line_parser_top.sv
// Ordinary bytes, backspace and empty line ends are handled in the idle state.
// Line end: trim scan from both ends, then a match pass over the kept characters,
// at most LINE_MAX-1 of them; in_ch is not ready again until idle, which waits while out is busy.
// The line store takes one write and one read per cycle; the line-end scan bounds the rate.
// Reset (rst_n low, synchronous) empties the line and drops any pending result.
`include "assert_macros.svh"
module serial_command_line_parser_top import sclp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  sclp_in_if.sink  in_ch,
  sclp_out_if.source out_ch
);

  logic [7:0] mem [LINE_MAX];

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  ptr_r, ptr_nxt;
  logic [LEN_W-1:0]  rd_idx_r;
  logic              rd_vld_r, rd_vld_nxt;
  logic [7:0]        rd_data_r;
  logic [LEN_W-1:0]  s_r, s_nxt;
  logic [ADDR_W-1:0] n_r, n_nxt;
  logic [ADDR_W-1:0] iss_left_r, iss_left_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic              scan_r, scan_nxt;
  logic [KW_N-1:0]   kw_ok_r, kw_ok_nxt;
  logic              per_ok_r, per_ok_nxt;
  logic              man_ok_r, man_ok_nxt;
  logic [ARG_W-1:0]  acc_p_r, acc_p_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_code_r, out_code_nxt;
  logic [ARG_W-1:0]  out_arg_r, out_arg_nxt;

  logic              issue;
  logic              mem_we;
  logic [7:0]        c_up;
  logic              blank;
  logic [LEN_W-1:0]  e_diff;
  logic [ARG_W+3:0]  prod_p;
  logic              hit;
  logic              kw_hit;
  cmd_code_t         hit_code;
  logic [ARG_W-1:0]  hit_arg;
  logic              in_acc;
  stg_ctl_t          ctl_a, ctl_b;
  stg_res_t          res_a, res_b;

  sclp_stage u_stage_man (.clk(clk), .ctl(ctl_a), .res(res_a));
  sclp_stage u_stage_fr  (.clk(clk), .ctl(ctl_b), .res(res_b));

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.cmd_code = out_code_r;
  assign out_ch.cmd_arg  = out_arg_r;

  assign c_up  = to_upper(rd_data_r);
  assign blank = (rd_data_r == CH_SP) || (rd_data_r == CH_TAB);

  // result select
  always_comb begin
    kw_hit   = 1'b0;
    hit_code = CMD_IDLE;
    hit_arg  = '0;
    for (int k = KW_N - 1; k >= 0; k--) begin
      if (kw_ok_r[k] && (int'(n_r) == KW_LEN[k])) begin
        kw_hit   = 1'b1;
        hit_code = KW_CODE[k];
      end
    end
    hit = kw_hit;
    if (!kw_hit) begin
      if (per_ok_r && (int'(n_r) > PER_LEN)) begin
        hit      = 1'b1;
        hit_code = CMD_PERIOD;
        hit_arg  = acc_p_r;
      end else if (man_ok_r && res_a.ok) begin
        hit      = 1'b1;
        hit_code = CMD_STAGE;
        hit_arg  = ARG_W'(res_a.val);
      end else if (res_b.ok && (res_b.mode != SM_NUM)) begin
        hit      = 1'b1;
        hit_code = CMD_STAGE;
        hit_arg  = ARG_W'(res_b.val);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    ptr_nxt       = ptr_r;
    s_nxt         = s_r;
    n_nxt         = n_r;
    iss_left_nxt  = iss_left_r;
    i_nxt         = i_r;
    scan_nxt      = scan_r;
    kw_ok_nxt     = kw_ok_r;
    per_ok_nxt    = per_ok_r;
    man_ok_nxt    = man_ok_r;
    acc_p_nxt     = acc_p_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_code_nxt  = out_code_r;
    out_arg_nxt   = out_arg_r;
    issue         = 1'b0;
    mem_we        = 1'b0;
    e_diff        = '0;
    prod_p        = (ARG_W+4)'(acc_p_r) * (ARG_W+4)'(10) + (ARG_W+4)'(c_up - 8'h30);
    ctl_a         = '{clr: 1'b0, en: 1'b0, first: 1'b0, c: c_up};
    ctl_b         = '{clr: 1'b0, en: 1'b0, first: 1'b0, c: c_up};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if ((in_ch.rx_byte == CH_CR) || (in_ch.rx_byte == CH_LF)) begin
            if (len_r != '0) begin
              state_nxt = ST_TRIM_S;
              ptr_nxt   = '0;
            end
          end else if ((in_ch.rx_byte == CH_BS) || (in_ch.rx_byte == CH_DEL)) begin
            if (len_r != '0) len_nxt = len_r - 1'b1;
          end else if (len_r < LEN_W'(LINE_MAX)) begin
            mem_we  = 1'b1;
            len_nxt = len_r + 1'b1;
          end else begin
            len_nxt = '0;
          end
        end
      end
      ST_TRIM_S: begin
        issue   = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (rd_vld_r) begin
          if (rd_idx_r >= len_r) begin
            state_nxt = ST_DONE;
            scan_nxt  = 1'b0;
          end else if (!blank) begin
            state_nxt = ST_TRIM_E;
            s_nxt     = rd_idx_r;
            ptr_nxt   = len_r - 1'b1;
          end
        end
      end
      ST_TRIM_E: begin
        issue   = 1'b1;
        ptr_nxt = ptr_r - 1'b1;
        if (rd_vld_r && !blank) begin
          e_diff       = rd_idx_r + 1'b1 - s_r;
          n_nxt        = (e_diff > LEN_W'(LINE_MAX - 1)) ? ADDR_W'(LINE_MAX - 1)
                                                         : e_diff[ADDR_W-1:0];
          state_nxt    = ST_MATCH;
          ptr_nxt      = s_r;
          iss_left_nxt = n_nxt;
          i_nxt        = '0;
          kw_ok_nxt    = '1;
          per_ok_nxt   = 1'b1;
          man_ok_nxt   = 1'b1;
          acc_p_nxt    = '0;
          ctl_a.clr    = 1'b1;
          ctl_b.clr    = 1'b1;
        end
      end
      ST_MATCH: begin
        if (iss_left_r != '0) begin
          issue        = 1'b1;
          ptr_nxt      = ptr_r + 1'b1;
          iss_left_nxt = iss_left_r - 1'b1;
        end
        if (rd_vld_r) begin
          for (int k = 0; k < KW_N; k++) begin
            if ((int'(i_r) >= KW_LEN[k]) || (c_up != txt_byte(KW_TXT[k], KW_LEN[k], int'(i_r))))
              kw_ok_nxt[k] = 1'b0;
          end
          if (int'(i_r) < PER_LEN) begin
            if (c_up != txt_byte(PER_TXT, PER_LEN, int'(i_r))) per_ok_nxt = 1'b0;
          end else if (!is_digit(c_up)) begin
            per_ok_nxt = 1'b0;
          end else begin
            acc_p_nxt = (prod_p > (ARG_W+4)'(SAT_MAX)) ? SAT_MAX : prod_p[ARG_W-1:0];
          end
          if (int'(i_r) < MAN_LEN) begin
            if (c_up != txt_byte(MAN_TXT, MAN_LEN, int'(i_r))) man_ok_nxt = 1'b0;
          end
          ctl_a.en    = (int'(i_r) >= MAN_LEN);
          ctl_a.first = (int'(i_r) == MAN_LEN);
          ctl_b.en    = 1'b1;
          ctl_b.first = (i_r == '0);
          i_nxt       = i_r + 1'b1;
          if (i_r == n_r - 1'b1) begin
            state_nxt = ST_DONE;
            scan_nxt  = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!(scan_r && hit)) begin
          state_nxt = ST_IDLE;
          len_nxt   = '0;
        end else if (!out_valid_nxt) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = hit_code;
          out_arg_nxt   = hit_arg;
          state_nxt     = ST_IDLE;
          len_nxt       = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    rd_vld_nxt = issue && (state_nxt == state_r);
  end

  // line store
  always_ff @(posedge clk) begin
    if (mem_we) mem[len_r[ADDR_W-1:0]] <= in_ch.rx_byte;
    rd_data_r <= mem[ptr_r[ADDR_W-1:0]];
    rd_idx_r  <= ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    s_r        <= s_nxt;
    n_r        <= n_nxt;
    iss_left_r <= iss_left_nxt;
    i_r        <= i_nxt;
    scan_r     <= scan_nxt;
    kw_ok_r    <= kw_ok_nxt;
    per_ok_r   <= per_ok_nxt;
    man_ok_r   <= man_ok_nxt;
    acc_p_r    <= acc_p_nxt;
    out_code_r <= out_code_nxt;
    out_arg_r  <= out_arg_nxt;
  end

  `SCLP_ASSERT_IMP(a_len_range, clk, rst_n, 1'b1, len_r <= LEN_W'(LINE_MAX))
  `SCLP_ASSERT_IMP(a_rd_not_idle, clk, rst_n, rd_vld_r, state_r != ST_IDLE)
  `SCLP_ASSERT_IMP(a_match_idx, clk, rst_n, (state_r == ST_MATCH) && rd_vld_r, i_r < n_r)
  `SCLP_ASSERT_NXT(a_done_leaves, clk, rst_n, (state_r == ST_DONE) && !out_valid_r,
                   state_r == ST_IDLE)

endmodule

### tb/tb.sv
module tb;
  import sclp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cmd_code_t        code;
    logic [ARG_W-1:0] arg;
  } cmd_t;

  typedef struct {
    string            text;
    bit               typed;
    cmd_code_t        code;
    logic [ARG_W-1:0] arg;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sclp_in_if  in_ch ();
  sclp_out_if out_ch ();

  serial_command_line_parser_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #4 clk = ~clk;

  cmd_t pending_cmds[$];
  int   mismatches = 0;
  int   snd_idle = 0;
  int   rcv_idle = 0;

  // predictor state
  logic [7:0] line_buf [LINE_MAX];
  int         line_len = 0;
  logic [7:0] tbuf [LINE_MAX];
  int         tn;

  function automatic bit text_at(int off, string k, bit whole);
    for (int i = 0; i < k.len(); i++) begin
      if (off + i >= tn || tbuf[off + i] != k[i]) return 1'b0;
    end
    return !whole || (off + k.len() == tn);
  endfunction

  function automatic bit read_dec(int off, output logic [ARG_W-1:0] v);
    logic [63:0] acc;
    acc = 0;
    v = 0;
    if (off >= tn) return 1'b0;
    for (int i = off; i < tn; i++) begin
      if (tbuf[i] < "0" || tbuf[i] > "9") return 1'b0;
      acc = acc * 10 + 64'(tbuf[i] - 8'h30);
      if (acc > SAT_MAX) acc = SAT_MAX;
    end
    v = acc[ARG_W-1:0];
    return 1'b1;
  endfunction

  function automatic bit read_stg(int off, output logic [ARG_W-1:0] v);
    logic [ARG_W-1:0] k;
    v = 0;
    if (off >= tn) return 1'b0;
    if (tbuf[off] == "F" || tbuf[off] == "R") begin
      if (!read_dec(off + 1, k)) return 1'b0;
      if (k < 1 || k > REVERSE_BASE) return 1'b0;
      v = (tbuf[off] == "F") ? ARG_W'(k - 1) : ARG_W'(REVERSE_BASE + k - 1);
      return 1'b1;
    end
    if (!read_dec(off, k)) return 1'b0;
    if (k < 1 || k > STAGE_COUNT) return 1'b0;
    v = ARG_W'(k - 1);
    return 1'b1;
  endfunction

  function automatic bit decode_line(output cmd_t r);
    int s, e;
    logic [ARG_W-1:0] v;
    logic [7:0] c;
    r.code = CMD_IDLE;
    r.arg = 0;
    s = 0;
    e = line_len;
    tn = 0;
    while (s < e && (line_buf[s] == CH_SP || line_buf[s] == CH_TAB)) s++;
    while (e > s && (line_buf[e-1] == CH_SP || line_buf[e-1] == CH_TAB)) e--;
    while (s < e && tn < LINE_MAX - 1) begin
      c = line_buf[s];
      s++;
      if (c >= "a" && c <= "z") c = c - 8'h20;
      tbuf[tn] = c;
      tn++;
    end
    if (tn == 0) return 1'b0;
    if (text_at(0, "IDLE", 1) || text_at(0, "0", 1)) begin r.code = CMD_IDLE; return 1; end
    if (text_at(0, "TRACK", 1) || text_at(0, "1", 1)) begin r.code = CMD_TRACK; return 1; end
    if (text_at(0, "MANUAL", 1) || text_at(0, "2", 1)) begin r.code = CMD_MANUAL; return 1; end
    if (text_at(0, "RECAL", 1)) begin r.code = CMD_RECAL; return 1; end
    if (text_at(0, "STATUS", 1)) begin r.code = CMD_STATUS; return 1; end
    if (text_at(0, "CAL?", 1)) begin r.code = CMD_CALQ; return 1; end
    if (text_at(0, "CFG?", 1)) begin r.code = CMD_CFGQ; return 1; end
    if (text_at(0, "HELP", 1)) begin r.code = CMD_HELP; return 1; end
    if (text_at(0, "PERIOD ", 0)) begin
      if (!read_dec(7, v)) return 1'b0;
      r.code = CMD_PERIOD; r.arg = v; return 1'b1;
    end
    if (text_at(0, "MAN ", 0)) begin
      if (!read_stg(4, v)) return 1'b0;
      r.code = CMD_STAGE; r.arg = v; return 1'b1;
    end
    if (tbuf[0] == "F" || tbuf[0] == "R") begin
      if (!read_stg(0, v)) return 1'b0;
      r.code = CMD_STAGE; r.arg = v; return 1'b1;
    end
    return 1'b0;
  endfunction

  // returns 1 when the word completes a command
  function automatic bit parse_word(logic [7:0] b, output cmd_t r);
    bit hit;
    r.code = CMD_IDLE;
    r.arg = 0;
    if (b == CH_CR || b == CH_LF) begin
      if (line_len == 0) return 1'b0;
      hit = decode_line(r);
      line_len = 0;
      return hit;
    end
    if (b == CH_BS || b == CH_DEL) begin
      if (line_len > 0) line_len--;
      return 1'b0;
    end
    if (line_len < LINE_MAX) begin
      line_buf[line_len] = b;
      line_len++;
    end else begin
      line_len = 0;
    end
    return 1'b0;
  endfunction

  task automatic send_word(logic [7:0] b, bit typed, cmd_t typed_cmd);
    cmd_t r;
    bit hit;
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    hit = parse_word(b, r);
    if (typed) begin
      if (b == CH_CR || b == CH_LF) pending_cmds.push_back(typed_cmd);
    end else if (hit) begin
      pending_cmds.push_back(r);
    end
  endtask

  task automatic send_bytes(logic [7:0] q[$]);
    cmd_t none;
    none.code = CMD_IDLE;
    none.arg = 0;
    foreach (q[i]) send_word(q[i], 1'b0, none);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  function automatic void add_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_num(ref logic [7:0] q[$], input int digits);
    for (int i = 0; i < digits; i++) q.push_back(8'("0" + $urandom_range(9)));
  endfunction

  function automatic void make_line(ref logic [7:0] q[$]);
    string kw [11] = '{"IDLE", "0", "TRACK", "1", "MANUAL", "2", "RECAL", "STATUS",
                       "CAL?", "CFG?", "HELP"};
    logic [7:0] body[$];
    int k;
    k = $urandom_range(99);
    repeat ($urandom_range(3) * ($urandom_range(2) == 0)) q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
    if (k < 30) begin
      add_text(body, kw[$urandom_range(10)]);
    end else if (k < 45) begin
      add_text(body, "PERIOD ");
      add_num(body, $urandom_range(3) == 0 ? $urandom_range(0, 14) : $urandom_range(1, 5));
    end else if (k < 60) begin
      add_text(body, "MAN ");
      if ($urandom_range(1)) body.push_back($urandom_range(1) ? "F" : "R");
      add_num(body, $urandom_range(0, 2));
    end else if (k < 75) begin
      body.push_back($urandom_range(1) ? "F" : "R");
      add_num(body, $urandom_range(0, 2));
    end else if (k < 85) begin
      add_num(body, $urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(1, 40)) body.push_back(8'($urandom_range(255)));
    end
    foreach (body[i]) begin
      if (body[i] >= "A" && body[i] <= "Z" && $urandom_range(3) == 0) body[i] = body[i] + 8'h20;
      if ($urandom_range(40) == 0) begin
        q.push_back(8'($urandom_range(255)));
        q.push_back($urandom_range(1) ? CH_BS : CH_DEL);
      end
      q.push_back(body[i]);
    end
    repeat ($urandom_range(2) * ($urandom_range(2) == 0)) q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
    if ($urandom_range(9) == 0) q.push_back(" ");
    q.push_back($urandom_range(1) ? CH_CR : CH_LF);
    if ($urandom_range(9) == 0) q.push_back($urandom_range(1) ? CH_CR : CH_LF);
  endfunction

  task automatic random_words(int count);
    logic [7:0] q[$];
    int sent;
    sent = 0;
    while (sent < count) begin
      q.delete();
      make_line(q);
      sent += q.size();
      send_bytes(q);
    end
  endtask

  // receiver and checker
  always @(posedge clk) begin
    cmd_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected command code=%0d arg=%0d", out_ch.cmd_code, out_ch.cmd_arg);
        end else begin
          want = pending_cmds.pop_front();
          if (out_ch.cmd_code !== want.code || out_ch.cmd_arg !== want.arg) begin
            mismatches++;
            if (mismatches <= 10)
              $display("command mismatch: exp code=%0d arg=%0d, got code=%0d arg=%0d",
                       want.code, want.arg, out_ch.cmd_code, out_ch.cmd_arg);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  stim_row_t stim_rows[$] = '{
    '{"idle\r", 1, CMD_IDLE, 0},
    '{"0\n", 1, CMD_IDLE, 0},
    '{"TRACK\r", 1, CMD_TRACK, 0},
    '{"1\r", 1, CMD_TRACK, 0},
    '{"manual\n", 1, CMD_MANUAL, 0},
    '{"2\r", 1, CMD_MANUAL, 0},
    '{"  ReCaL\t \r", 1, CMD_RECAL, 0},
    '{"status\r", 1, CMD_STATUS, 0},
    '{"cal?\r", 1, CMD_CALQ, 0},
    '{"\tCFG?\r", 1, CMD_CFGQ, 0},
    '{"help\r", 1, CMD_HELP, 0},
    '{"PERIOD 0\r", 1, CMD_PERIOD, 0},
    '{"period 99999999999\r", 1, CMD_PERIOD, 31'h7FFF_FFFF},
    '{"PERIOD 2147483647\r", 1, CMD_PERIOD, 31'h7FFF_FFFF},
    '{"f1\r", 1, CMD_STAGE, 0},
    '{"R7\r", 1, CMD_STAGE, 13},
    '{"MAN 14\r", 1, CMD_STAGE, 13},
    '{"MAN 99999999999\r", 0, CMD_IDLE, 0},
    '{"F8\rR0\rPERIOD \rPERIOD  5\rMAN 15\r", 0, CMD_IDLE, 0},
    '{"\r\n   \t\r\010\177", 0, CMD_IDLE, 0},
    '{"HELPX\010\r", 1, CMD_HELP, 0},
    '{"STATUS\177\177\177\177\177\177\177\rMAN F3\r", 0, CMD_IDLE, 0},
    '{"AAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAhelp\r", 0, CMD_IDLE, 0},
    '{"   PERIOD 1234567890123456789012345\r", 0, CMD_IDLE, 0},
    '{"                              track  \r", 0, CMD_IDLE, 0}
  };

  initial begin
    cmd_t tc;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[r]) begin
      tc.code = stim_rows[r].code;
      tc.arg  = stim_rows[r].arg;
      for (int i = 0; i < stim_rows[r].text.len(); i++)
        send_word(stim_rows[r].text[i], stim_rows[r].typed, tc);
    end
    wait_drained();

    snd_idle = 24; rcv_idle = 76;
    random_words(60);
    wait_drained();
    snd_idle = 76; rcv_idle = 24;
    random_words(60);
    snd_idle = 0; rcv_idle = 0;
    random_words(60);

    wait_drained();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0)
      $display("serial_command_line_parser_top regression: pass");
    else
      $display("serial_command_line_parser_top regression: fail");
    $finish;
  end

  initial begin
    #(8 * 2_000_000);
    $display("serial_command_line_parser_top regression: fail");
    $finish;
  end

endmodule
